/* design/wavp_pkg.sv */
// shared types, constants and helpers for the wave header parser
package wavp_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] FMT_LEN   = 32'd16;
  localparam logic [5:0]  TAG_END   = 6'd40;

  // header offsets where a field is complete
  localparam logic [5:0] POS_RIFF_SIZE = 6'd7;
  localparam logic [5:0] POS_FMT_SIZE  = 6'd19;
  localparam logic [5:0] POS_CHANNELS  = 6'd23;
  localparam logic [5:0] POS_RATE      = 6'd27;
  localparam logic [5:0] POS_BITS      = 6'd35;
  localparam logic [5:0] POS_DATA_SIZE = 6'd43;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SHORT     = 4'd1,
    ST_RIFF      = 4'd2,
    ST_RIFF_SIZE = 4'd3,
    ST_WAVE      = 4'd4,
    ST_FMT       = 4'd5,
    ST_FMT_SIZE  = 4'd6,
    ST_DATA_TAG  = 4'd7,
    ST_DATA_SIZE = 4'd8
  } status_e;

  typedef struct packed {
    status_e    code;
    logic [7:0] ch;
  } tag_t;

  // request carried from the front end to the back end
  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        done;
    logic        short_f;
    logic        riff_size_bad;
    logic        data_size_bad;
    status_e     first_fail;
    logic [15:0] channels;
    logic [15:0] sample_bits;
    logic [31:0] rate_hz;
    logic [31:0] data_bytes;
  } job_t;

  // expected tag character at a header offset, code ST_OK where none
  function automatic tag_t tag_want(input logic [5:0] pos);
    tag_t t;
    t.code = ST_OK;
    t.ch   = 8'h00;
    case (pos)
      6'd0:  begin t.code = ST_RIFF;     t.ch = 8'h52; end
      6'd1:  begin t.code = ST_RIFF;     t.ch = 8'h49; end
      6'd2:  begin t.code = ST_RIFF;     t.ch = 8'h46; end
      6'd3:  begin t.code = ST_RIFF;     t.ch = 8'h46; end
      6'd8:  begin t.code = ST_WAVE;     t.ch = 8'h57; end
      6'd9:  begin t.code = ST_WAVE;     t.ch = 8'h41; end
      6'd10: begin t.code = ST_WAVE;     t.ch = 8'h56; end
      6'd11: begin t.code = ST_WAVE;     t.ch = 8'h45; end
      6'd12: begin t.code = ST_FMT;      t.ch = 8'h66; end
      6'd13: begin t.code = ST_FMT;      t.ch = 8'h6D; end
      6'd14: begin t.code = ST_FMT;      t.ch = 8'h74; end
      6'd15: begin t.code = ST_FMT;      t.ch = 8'h20; end
      6'd36: begin t.code = ST_DATA_TAG; t.ch = 8'h64; end
      6'd37: begin t.code = ST_DATA_TAG; t.ch = 8'h61; end
      6'd38: begin t.code = ST_DATA_TAG; t.ch = 8'h74; end
      6'd39: begin t.code = ST_DATA_TAG; t.ch = 8'h61; end
      default: begin t.code = ST_OK;     t.ch = 8'h00; end
    endcase
    return t;
  endfunction

endpackage

/* design/wavp_in_if.sv */
// input byte channel
interface wavp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

/* design/wavp_out_if.sv */
// result channel
interface wavp_out_if;
  logic        valid;
  logic        ready;
  logic        byte_valid;
  logic [7:0]  out_byte;
  logic        done_res;
  logic [3:0]  status;
  logic [15:0] channels;
  logic [15:0] sample_bits;
  logic [31:0] rate_hz;
  logic [31:0] data_bytes;

  modport source (output valid, output byte_valid, output out_byte, output done_res,
                  output status, output channels, output sample_bits,
                  output rate_hz, output data_bytes, input ready);
  modport sink   (input valid, input byte_valid, input out_byte, input done_res,
                  input status, input channels, input sample_bits,
                  input rate_hz, input data_bytes, output ready);
endinterface

/* design/wavp_front.sv */
// front end: byte counter, tag checks, field assembly and request build
module wavp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  wavp_in_if.sink            in_i,
  output logic               push_valid_o,
  output wavp_pkg::job_t     push_job_o,
  input  logic               push_ready_i
);

  logic [31:0]       count_q, count_d;
  wavp_pkg::status_e fail_q, fail_d;
  logic [31:0]       shift_q, shift_d;
  logic [31:0]       riff_size_q, riff_size_d;
  logic [31:0]       data_size_q, data_size_d;
  logic [31:0]       rate_q, rate_d;
  logic [15:0]       chan_q, chan_d;
  logic [15:0]       bits_q, bits_d;

  logic              accept;
  logic              sat;
  logic              in_hdr;
  logic [5:0]        pos;
  wavp_pkg::tag_t    tag;
  logic              pass;

  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid & in_i.ready;
  assign sat        = (count_q == wavp_pkg::COUNT_MAX);
  assign in_hdr     = (count_q[31:6] == 26'd0);
  assign pos        = count_q[5:0];
  assign tag        = wavp_pkg::tag_want(pos);
  assign shift_d    = {in_i.in_byte, shift_q[31:8]};
  assign pass       = !(in_hdr && (pos < 6'd44)) && (fail_q == wavp_pkg::ST_OK);

  always_comb begin
    count_d     = sat ? count_q : count_q + 32'd1;
    fail_d      = fail_q;
    riff_size_d = riff_size_q;
    data_size_d = data_size_q;
    rate_d      = rate_q;
    chan_d      = chan_q;
    bits_d      = bits_q;
    if (in_hdr && (pos < wavp_pkg::TAG_END) && (tag.code != wavp_pkg::ST_OK) &&
        (in_i.in_byte != tag.ch)) begin
      if ((fail_d == wavp_pkg::ST_OK) || (tag.code < fail_d)) fail_d = tag.code;
    end
    if (in_hdr) begin
      case (pos)
        wavp_pkg::POS_RIFF_SIZE: riff_size_d = shift_d;
        wavp_pkg::POS_FMT_SIZE: begin
          if ((shift_d != wavp_pkg::FMT_LEN) &&
              ((fail_d == wavp_pkg::ST_OK) || (wavp_pkg::ST_FMT_SIZE < fail_d))) begin
            fail_d = wavp_pkg::ST_FMT_SIZE;
          end
        end
        wavp_pkg::POS_CHANNELS:  chan_d      = shift_d[31:16];
        wavp_pkg::POS_RATE:      rate_d      = shift_d;
        wavp_pkg::POS_BITS:      bits_d      = shift_d[31:16];
        wavp_pkg::POS_DATA_SIZE: data_size_d = shift_d;
        default: ;
      endcase
    end
  end

  // request contents; size compares use held values, a short file masks them
  always_comb begin
    push_job_o               = '0;
    push_job_o.byte_valid    = pass;
    push_job_o.out_byte      = pass ? in_i.in_byte : 8'h00;
    push_job_o.done          = in_i.is_final;
    push_job_o.short_f       = !sat && in_hdr && (pos <= 6'd43);
    push_job_o.riff_size_bad = (count_d == wavp_pkg::COUNT_MAX) ||
                               (riff_size_q != (count_q - 32'd7));
    push_job_o.data_size_bad = (({1'b0, data_size_q} + 33'd43) != {1'b0, count_q});
    push_job_o.first_fail    = fail_q;
    push_job_o.channels      = chan_d;
    push_job_o.sample_bits   = bits_d;
    push_job_o.rate_hz       = rate_d;
    push_job_o.data_bytes    = data_size_d;
  end

  assign push_valid_o = accept && (pass || in_i.is_final);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      fail_q      <= wavp_pkg::ST_OK;
      shift_q     <= '0;
      riff_size_q <= '0;
      data_size_q <= '0;
      rate_q      <= '0;
      chan_q      <= '0;
      bits_q      <= '0;
    end else if (accept) begin
      if (in_i.is_final) begin
        count_q     <= '0;
        fail_q      <= wavp_pkg::ST_OK;
        shift_q     <= '0;
        riff_size_q <= '0;
        data_size_q <= '0;
        rate_q      <= '0;
        chan_q      <= '0;
        bits_q      <= '0;
      end else begin
        count_q     <= count_d;
        fail_q      <= fail_d;
        shift_q     <= shift_d;
        riff_size_q <= riff_size_d;
        data_size_q <= data_size_d;
        rate_q      <= rate_d;
        chan_q      <= chan_d;
        bits_q      <= bits_d;
      end
    end
  end

endmodule

/* design/wavp_queue.sv */
// small request queue between front and back end
module wavp_queue #(
  parameter int unsigned Depth = wavp_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  wavp_pkg::job_t push_job_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output wavp_pkg::job_t pop_job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  wavp_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_job_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      if (pop)  rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      if (push && !pop)      count_q <= count_q + CntW'(1);
      else if (pop && !push) count_q <= count_q - CntW'(1);
    end
  end

endmodule

/* design/wavp_back.sv */
// back end: status priority and output register
module wavp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  wavp_pkg::job_t pop_job_i,
  wavp_out_if.source     out_o
);

  logic              valid_q;
  logic              load;
  wavp_pkg::status_e st_d;
  logic              bv_q;
  logic [7:0]        byte_q;
  logic              done_q;
  wavp_pkg::status_e st_q;
  logic [15:0]       chan_q, bits_q;
  logic [31:0]       rate_q, dsize_q;

  assign pop_ready_o = !valid_q || out_o.ready;
  assign load        = pop_valid_i && pop_ready_o;

  always_comb begin
    if (!pop_job_i.done)                                st_d = wavp_pkg::ST_OK;
    else if (pop_job_i.short_f)                         st_d = wavp_pkg::ST_SHORT;
    else if (pop_job_i.first_fail == wavp_pkg::ST_RIFF) st_d = wavp_pkg::ST_RIFF;
    else if (pop_job_i.riff_size_bad)                   st_d = wavp_pkg::ST_RIFF_SIZE;
    else if (pop_job_i.first_fail != wavp_pkg::ST_OK)   st_d = pop_job_i.first_fail;
    else if (pop_job_i.data_size_bad)                   st_d = wavp_pkg::ST_DATA_SIZE;
    else                                                st_d = wavp_pkg::ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_ready_o) begin
      valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bv_q    <= pop_job_i.byte_valid;
      byte_q  <= pop_job_i.out_byte;
      done_q  <= pop_job_i.done;
      st_q    <= st_d;
      chan_q  <= pop_job_i.done ? pop_job_i.channels    : 16'd0;
      bits_q  <= pop_job_i.done ? pop_job_i.sample_bits : 16'd0;
      rate_q  <= pop_job_i.done ? pop_job_i.rate_hz     : 32'd0;
      dsize_q <= pop_job_i.done ? pop_job_i.data_bytes  : 32'd0;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.byte_valid  = bv_q;
  assign out_o.out_byte    = byte_q;
  assign out_o.done_res    = done_q;
  assign out_o.status      = st_q;
  assign out_o.channels    = chan_q;
  assign out_o.sample_bits = bits_q;
  assign out_o.rate_hz     = rate_q;
  assign out_o.data_bytes  = dsize_q;

endmodule

/* design/wav_header_parser.sv */
// top level of the riff/wave pcm header parser
// a request is queued as its byte is accepted, then loaded into the output register
// throughput: one byte per cycle while the queue has room; a full queue stalls the input
// non-final header bytes and non-final bytes after a failed check produce no request
// reset: asynchronous active low, clears counters, check state, queue and output valid
// after a final byte all header state returns to reset so the next byte opens a new file
module wav_header_parser #(
  parameter int unsigned QueueDepth = wavp_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wavp_in_if.sink    in_i,
  wavp_out_if.source out_o
);

  // request path from front end to back end
  logic           push_valid, push_ready;
  wavp_pkg::job_t push_job;
  logic           pop_valid, pop_ready;
  wavp_pkg::job_t pop_job;

  // front end: counts bytes, checks tags and fmt size, assembles fields
  wavp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_job_o   (push_job),
    .push_ready_i (push_ready)
  );

  // decoupling queue, lets either side stall on its own
  wavp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  // back end: resolves status in check order and holds the result
  wavp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .out_o       (out_o)
  );

`ifndef ASSERT_OFF
  // a request is only raised when the queue can take it
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> push_ready) else $error("request pushed into full queue");

  // every result carries a data byte or the end of file
  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.byte_valid || out_o.done_res))
    else $error("empty result shown");

  // status only reported on the final result
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.done_res) |-> (out_o.status == wavp_pkg::ST_OK))
    else $error("status on non-final result");

  // data byte field is clear when no data byte is carried
  a_byte_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.byte_valid) |-> (out_o.out_byte == 8'h00))
    else $error("stray data byte");
`endif

endmodule

/* bench/tb_wav_header_parser.sv */
// self-checking testbench for the riff/wave header parser
`timescale 1ns / 100ps

module tb_wav_header_parser;

  // tags as big-endian character words, first character in the top byte
  localparam logic [31:0] TAG_RIFF = "RIFF";
  localparam logic [31:0] TAG_WAVE = "WAVE";
  localparam logic [31:0] TAG_FMT  = "fmt ";
  localparam logic [31:0] TAG_DATA = "data";

  localparam int unsigned HDR_BYTES     = 44;
  localparam logic [31:0] FMT_CHUNK     = 32'd16;
  localparam logic [31:0] RIFF_PREAMBLE = 32'd8;

  // offsets of the last byte of each little-endian field
  localparam int unsigned OFS_RIFF_SIZE_END = 7;
  localparam int unsigned OFS_FMT_SIZE_END  = 19;
  localparam int unsigned OFS_CHANNELS_END  = 23;
  localparam int unsigned OFS_RATE_END      = 27;
  localparam int unsigned OFS_BITS_END      = 35;
  localparam int unsigned OFS_DATA_SIZE_END = 43;

  localparam int unsigned BYTE_TARGET = 1450;
  localparam int unsigned PHASE1_AT   = 480;
  localparam int unsigned PHASE2_AT   = 960;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned TAIL_CYCLES = 10;

  // what a random file looks like before it is streamed in
  typedef enum int {
    FK_GOOD, FK_RIFF_TAG, FK_RIFF_SIZE, FK_WAVE_TAG, FK_FMT_TAG, FK_FMT_SIZE,
    FK_DATA_TAG, FK_DATA_SIZE, FK_MULTI, FK_TRUNC, FK_NOISE
  } file_kind_e;

  typedef struct packed {
    logic              byte_valid;
    logic [7:0]        out_byte;
    logic              done_res;
    wavp_pkg::status_e status;
    logic [15:0]       channels;
    logic [15:0]       sample_bits;
    logic [31:0]       rate_hz;
    logic [31:0]       data_bytes;
  } wave_result_t;

  // one row of the directed table; exp_short marks a row whose request
  // must come back as a short-file status with every field zero
  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
    logic       exp_short;
  } dir_row_t;

  logic clk;
  logic rst_n;

  wavp_in_if  in_if ();
  wavp_out_if out_if ();

  wav_header_parser dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // directed part: one-byte files at both extremes, a bare tag, a tag plus
  // a riff size that is assembled but never reported, and broken tags
  dir_row_t directed_rows [18] = '{
    '{8'h00, 1'b1, 1'b1},
    '{8'hFF, 1'b1, 1'b1},
    '{"R",   1'b0, 1'b0},
    '{"I",   1'b0, 1'b0},
    '{"F",   1'b0, 1'b0},
    '{"F",   1'b1, 1'b1},
    '{"R",   1'b0, 1'b0},
    '{"I",   1'b0, 1'b0},
    '{"F",   1'b0, 1'b0},
    '{"F",   1'b0, 1'b0},
    '{8'h78, 1'b0, 1'b0},
    '{8'h56, 1'b0, 1'b0},
    '{8'h34, 1'b0, 1'b0},
    '{8'h12, 1'b1, 1'b1},
    '{8'hA5, 1'b0, 1'b0},
    '{8'h5A, 1'b1, 1'b1},
    '{8'h80, 1'b0, 1'b0},
    '{8'h7F, 1'b1, 1'b1}
  };

  wave_result_t pending_results [$];
  logic [7:0]   wave_file [$];

  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned tx_idle_pct    = 20;
  int unsigned rx_idle_pct    = 50;

  // header state of the predictor
  logic [31:0]       hdr_count;
  wavp_pkg::status_e hdr_fail;
  logic [31:0]       hdr_shift;
  logic [31:0]       hdr_riff_size;
  logic [31:0]       hdr_fmt_size;
  logic [31:0]       hdr_data_size;
  logic [31:0]       hdr_rate;
  logic [15:0]       hdr_channels;
  logic [15:0]       hdr_bits;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_header_state();
    hdr_count     = '0;
    hdr_fail      = wavp_pkg::ST_OK;
    hdr_shift     = '0;
    hdr_riff_size = '0;
    hdr_fmt_size  = '0;
    hdr_data_size = '0;
    hdr_rate      = '0;
    hdr_channels  = '0;
    hdr_bits      = '0;
  endfunction

  // only the lowest failing check is kept
  function automatic void note_header_fault(input wavp_pkg::status_e code);
    if (hdr_fail == wavp_pkg::ST_OK || code < hdr_fail) hdr_fail = code;
  endfunction

  // advance the header state by one byte and work out the request it causes
  function automatic void parse_wave_byte(input logic [7:0] b, input logic fin,
                                          output bit has_res, output wave_result_t res);
    logic [31:0]       pos;
    logic [31:0]       n;
    wavp_pkg::status_e code;
    logic [31:0]       tag;
    logic              pass;
    pos  = hdr_count;
    code = wavp_pkg::ST_OK;
    tag  = '0;
    if (pos < 4) begin
      code = wavp_pkg::ST_RIFF;
      tag  = TAG_RIFF;
    end else if (pos >= 8 && pos < 12) begin
      code = wavp_pkg::ST_WAVE;
      tag  = TAG_WAVE;
    end else if (pos >= 12 && pos < 16) begin
      code = wavp_pkg::ST_FMT;
      tag  = TAG_FMT;
    end else if (pos >= 36 && pos < 40) begin
      code = wavp_pkg::ST_DATA_TAG;
      tag  = TAG_DATA;
    end
    // every tag starts on a four-byte boundary, so the low bits index it
    if (code != wavp_pkg::ST_OK && b != tag[8*(3-pos[1:0]) +: 8]) note_header_fault(code);

    hdr_shift = {b, hdr_shift[31:8]};
    case (pos)
      OFS_RIFF_SIZE_END: hdr_riff_size = hdr_shift;
      OFS_FMT_SIZE_END: begin
        hdr_fmt_size = hdr_shift;
        if (hdr_fmt_size != FMT_CHUNK) note_header_fault(wavp_pkg::ST_FMT_SIZE);
      end
      OFS_CHANNELS_END:  hdr_channels  = hdr_shift[31:16];
      OFS_RATE_END:      hdr_rate      = hdr_shift;
      OFS_BITS_END:      hdr_bits      = hdr_shift[31:16];
      OFS_DATA_SIZE_END: hdr_data_size = hdr_shift;
      default: ;
    endcase

    pass = (pos >= HDR_BYTES) && (hdr_fail == wavp_pkg::ST_OK);
    if (hdr_count != '1) hdr_count = hdr_count + 32'd1;

    has_res        = pass || fin;
    res            = '0;
    res.status     = wavp_pkg::ST_OK;
    res.byte_valid = pass;
    res.out_byte   = pass ? b : 8'h00;
    if (fin) begin
      n = hdr_count;
      if (n <= HDR_BYTES) res.status = wavp_pkg::ST_SHORT;
      else if (hdr_fail == wavp_pkg::ST_RIFF) res.status = wavp_pkg::ST_RIFF;
      else if (n == '1 || hdr_riff_size != n - RIFF_PREAMBLE)
        res.status = wavp_pkg::ST_RIFF_SIZE;
      else if (hdr_fail != wavp_pkg::ST_OK) res.status = hdr_fail;
      else if ({1'b0, hdr_data_size} + 33'd44 != {1'b0, n})
        res.status = wavp_pkg::ST_DATA_SIZE;
      else res.status = wavp_pkg::ST_OK;
      res.done_res    = 1'b1;
      res.channels    = hdr_channels;
      res.sample_bits = hdr_bits;
      res.rate_hz     = hdr_rate;
      res.data_bytes  = hdr_data_size;
      clear_header_state();
    end
  endfunction

  // field values lean towards their extremes
  function automatic logic [15:0] pick16();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] nonzero32();
    logic [31:0] v;
    v = $urandom_range(1) ? (32'h1 << $urandom_range(31)) : $urandom;
    if (v == '0) v = 32'h1;
    return v;
  endfunction

  function automatic void put_le(input int ofs, input logic [31:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++) wave_file[ofs+i] = v[8*i +: 8];
  endfunction

  function automatic void put_tag(input int ofs, input logic [31:0] tag);
    for (int i = 0; i < 4; i++) wave_file[ofs+i] = tag[8*(3-i) +: 8];
  endfunction

  function automatic void flip_tag_byte(input int base);
    int i;
    i = base + $urandom_range(3);
    wave_file[i] = wave_file[i] ^ 8'($urandom_range(1, 255));
  endfunction

  // break the one header check named by code; n is the file length
  function automatic void spoil_header(input wavp_pkg::status_e code, input int n);
    case (code)
      wavp_pkg::ST_RIFF:      flip_tag_byte(0);
      wavp_pkg::ST_RIFF_SIZE: put_le(4, (n - RIFF_PREAMBLE) ^ nonzero32(), 4);
      wavp_pkg::ST_WAVE:      flip_tag_byte(8);
      wavp_pkg::ST_FMT:       flip_tag_byte(12);
      wavp_pkg::ST_FMT_SIZE:  put_le(16, FMT_CHUNK ^ nonzero32(), 4);
      wavp_pkg::ST_DATA_TAG:  flip_tag_byte(36);
      wavp_pkg::ST_DATA_SIZE: put_le(40, (n - HDR_BYTES) ^ nonzero32(), 4);
      default: ;
    endcase
  endfunction

  function automatic wavp_pkg::status_e any_check();
    return wavp_pkg::status_e'($urandom_range(wavp_pkg::ST_RIFF, wavp_pkg::ST_DATA_SIZE));
  endfunction

  // lay out a whole file, then spoil it as the kind asks
  function automatic void build_wave_file(input file_kind_e kind);
    int data_len;
    int n;
    int keep;
    wave_file.delete();
    if (kind == FK_NOISE) begin
      repeat ($urandom_range(1, 70)) wave_file.push_back(8'($urandom));
      return;
    end
    // mostly short payloads, now and then a longer one; zero gives a short file
    data_len = ($urandom_range(9) == 0) ? $urandom_range(21, 120) : $urandom_range(0, 20);
    n = HDR_BYTES + data_len;
    repeat (n) wave_file.push_back(8'($urandom));
    put_tag(0, TAG_RIFF);
    put_le(4, n - RIFF_PREAMBLE, 4);
    put_tag(8, TAG_WAVE);
    put_tag(12, TAG_FMT);
    put_le(16, FMT_CHUNK, 4);
    put_le(22, 32'(pick16()), 2);
    put_le(24, pick32(), 4);
    put_le(34, 32'(pick16()), 2);
    put_tag(36, TAG_DATA);
    put_le(40, data_len, 4);
    case (kind)
      FK_RIFF_TAG:  spoil_header(wavp_pkg::ST_RIFF, n);
      FK_RIFF_SIZE: spoil_header(wavp_pkg::ST_RIFF_SIZE, n);
      FK_WAVE_TAG:  spoil_header(wavp_pkg::ST_WAVE, n);
      FK_FMT_TAG:   spoil_header(wavp_pkg::ST_FMT, n);
      FK_FMT_SIZE:  spoil_header(wavp_pkg::ST_FMT_SIZE, n);
      FK_DATA_TAG:  spoil_header(wavp_pkg::ST_DATA_TAG, n);
      FK_DATA_SIZE: spoil_header(wavp_pkg::ST_DATA_SIZE, n);
      FK_MULTI:     repeat ($urandom_range(2, 3)) spoil_header(any_check(), n);
      FK_TRUNC: begin
        if ($urandom_range(1)) spoil_header(any_check(), n);
        keep = $urandom_range(1, 50);
        while (wave_file.size() > keep) void'(wave_file.pop_back());
      end
      default: ;
    endcase
  endfunction

  // present one byte, idling first as the phase asks, and wait for the byte
  // to be taken; valid stays high so back-to-back bytes leave no gap
  task automatic offer_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.in_byte  <= b;
    in_if.is_final <= fin;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // hold the sender back until every expected request has come out
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endfunction

  // receiver: back-pressure at the rate the phase asks
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // every request leaving the block is matched against the oldest expectation
  always @(posedge clk) begin : result_check
    wave_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected request, expected none, actual byte %0h done %0b status %0d",
                 $time, out_if.out_byte, out_if.done_res, out_if.status);
      end else begin
        want = pending_results.pop_front();
        check_field("byte_valid",  32'(want.byte_valid),  32'(out_if.byte_valid));
        check_field("out_byte",    32'(want.out_byte),    32'(out_if.out_byte));
        check_field("done_res",    32'(want.done_res),    32'(out_if.done_res));
        check_field("status",      32'(want.status),      32'(out_if.status));
        check_field("channels",    32'(want.channels),    32'(out_if.channels));
        check_field("sample_bits", 32'(want.sample_bits), 32'(out_if.sample_bits));
        check_field("rate_hz",     want.rate_hz,          out_if.rate_hz);
        check_field("data_bytes",  want.data_bytes,       out_if.data_bytes);
      end
    end
  end

  // watchdog: too long without any request moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wave_result_t res;
    bit           has_res;
    file_kind_e   kind;
    int           files_made;
    int           phase;

    files_made = 0;
    phase      = 0;
    clear_header_state();
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.in_byte  <= 8'h00;
    in_if.is_final <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: the predictor is stepped too so it stays in line
    foreach (directed_rows[i]) begin
      offer_byte(directed_rows[i].in_byte, directed_rows[i].is_final);
      parse_wave_byte(directed_rows[i].in_byte, directed_rows[i].is_final, has_res, res);
      if (directed_rows[i].exp_short) begin
        res          = '0;
        res.done_res = 1'b1;
        res.status   = wavp_pkg::ST_SHORT;
        pending_results.push_back(res);
      end
    end
    drain_results();

    // random files: the first pass walks every kind once, after that half
    // the files are well formed with random content
    while (bytes_sent < BYTE_TARGET) begin
      if (phase == 0 && bytes_sent >= PHASE1_AT) begin
        drain_results();
        phase       = 1;
        tx_idle_pct = 50;
        rx_idle_pct = 20;
      end else if (phase == 1 && bytes_sent >= PHASE2_AT) begin
        drain_results();
        phase       = 2;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (files_made <= FK_NOISE) kind = file_kind_e'(files_made);
      else if ($urandom_range(1)) kind = FK_GOOD;
      else kind = file_kind_e'($urandom_range(FK_RIFF_TAG, FK_NOISE));
      build_wave_file(kind);
      files_made++;
      foreach (wave_file[i]) begin
        offer_byte(wave_file[i], i == wave_file.size() - 1);
        parse_wave_byte(wave_file[i], i == wave_file.size() - 1, has_res, res);
        if (has_res) pending_results.push_back(res);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
